// ----- sv/kst_pkg.sv -----
// package: shared types, codes and character tables of the scan code translator
`default_nettype none
package kst_pkg;

  localparam int KST_CMD_QUEUE_DEPTH = 32;

  // bytes from and to the keyboard
  localparam logic [7:0] KST_CODE_LED_CMD    = 8'hED;
  localparam logic [7:0] KST_CODE_ACK        = 8'hFA;
  localparam logic [7:0] KST_CODE_RESEND     = 8'hFE;
  localparam logic [7:0] KST_CODE_LSHIFT_ON  = 8'h2A;
  localparam logic [7:0] KST_CODE_RSHIFT_ON  = 8'h36;
  localparam logic [7:0] KST_CODE_LSHIFT_OFF = 8'hAA;
  localparam logic [7:0] KST_CODE_RSHIFT_OFF = 8'hB6;
  localparam logic [7:0] KST_CODE_CAPS       = 8'h3A;
  localparam logic [7:0] KST_CODE_NUM        = 8'h45;
  localparam logic [7:0] KST_CODE_SCROLL     = 8'h46;
  localparam logic [7:0] KST_CODE_BACKSPACE  = 8'h0E;
  localparam logic [7:0] KST_CODE_TAB        = 8'h0F;
  localparam logic [7:0] KST_CODE_ENTER      = 8'h1C;

  // result kinds
  localparam logic [2:0] KST_KIND_CHAR      = 3'd0;
  localparam logic [2:0] KST_KIND_BACKSPACE = 3'd1;
  localparam logic [2:0] KST_KIND_ENTER     = 3'd2;
  localparam logic [2:0] KST_KIND_TAB       = 3'd3;
  localparam logic [2:0] KST_KIND_SEND      = 3'd4;

  // led bit masks
  localparam logic [2:0] KST_LED_SCROLL = 3'b001;
  localparam logic [2:0] KST_LED_NUM    = 3'b010;
  localparam logic [2:0] KST_LED_CAPS   = 3'b100;

  localparam logic [7:0] KST_UPPER_A = 8'h41;
  localparam logic [7:0] KST_UPPER_Z = 8'h5A;
  localparam logic [7:0] KST_CASE_OFFSET = 8'h20;

  // classified keyboard byte handed from front to back
  typedef struct packed {
    logic [7:0] ch;
    logic       bksp;
    logic       tab;
    logic       enter;
    logic       ack;
    logic       resend;
    logic       toggle;
    logic [2:0] leds;
  } kst_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_MID,
    ST_PUT_CMD,
    ST_PUT_LED,
    ST_SETTLE,
    ST_SEND
  } kst_state_e;

  localparam logic [7:0] KST_PLAIN_MAP [128] = '{
    8'h00, 8'h60, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h5B, 8'h5D, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3B,
    8'h27, 8'h00, 8'h00, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5C, 8'h00, 8'h00
  };

  localparam logic [7:0] KST_SHIFTED_MAP [128] = '{
    8'h00, 8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h00, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h5F, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7C, 8'h00, 8'h00
  };

endpackage
`default_nettype wire

// ----- sv/kst_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module kst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- sv/kst_front.sv -----
// front end: accepts keyboard bytes, tracks shift and led state, classifies each byte
`default_nettype none
module kst_front
  import kst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] code_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_initial_leds_i,
  input  wire logic       fifo_full_i,
  output logic            push_o,
  output kst_op_t         op_o,
  output logic [2:0]      boot_leds_o
);

  logic [1:0] shift_q, shift_d;
  logic [2:0] leds_q, leds_d;
  logic [2:0] init_leds_q;
  logic       started_q;
  logic       accept;
  logic       cfg_load;
  logic       shifted;
  logic [7:0] ch_raw;
  logic       is_letter;
  logic [2:0] toggle_mask;

  assign in_ready_o  = !fifo_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_load    = cfg_valid_i && !started_q;
  assign push_o      = accept;
  assign boot_leds_o = init_leds_q;
  assign shifted     = (shift_q != 2'b00);

  always_comb begin
    if (code_i[7]) begin
      ch_raw = 8'h00;
    end else if (shifted) begin
      ch_raw = KST_SHIFTED_MAP[code_i[6:0]];
    end else begin
      ch_raw = KST_PLAIN_MAP[code_i[6:0]];
    end
  end

  assign is_letter = (ch_raw >= KST_UPPER_A) && (ch_raw <= KST_UPPER_Z);

  always_comb begin
    unique case (code_i)
      KST_CODE_CAPS:   toggle_mask = KST_LED_CAPS;
      KST_CODE_NUM:    toggle_mask = KST_LED_NUM;
      KST_CODE_SCROLL: toggle_mask = KST_LED_SCROLL;
      default:         toggle_mask = 3'b000;
    endcase
  end

  always_comb begin
    shift_d = shift_q;
    unique case (code_i)
      KST_CODE_LSHIFT_ON:  shift_d = shift_q | 2'b01;
      KST_CODE_RSHIFT_ON:  shift_d = shift_q | 2'b10;
      KST_CODE_LSHIFT_OFF: shift_d = shift_q & 2'b10;
      KST_CODE_RSHIFT_OFF: shift_d = shift_q & 2'b01;
      default:             shift_d = shift_q;
    endcase
  end

  assign leds_d = leds_q ^ toggle_mask;

  always_comb begin
    // lower case when caps lock and shift agree
    op_o.ch     = (is_letter && (leds_q[2] == shifted)) ? ch_raw + KST_CASE_OFFSET : ch_raw;
    op_o.bksp   = (code_i == KST_CODE_BACKSPACE);
    op_o.tab    = (code_i == KST_CODE_TAB);
    op_o.enter  = (code_i == KST_CODE_ENTER);
    op_o.ack    = (code_i == KST_CODE_ACK);
    op_o.resend = (code_i == KST_CODE_RESEND);
    op_o.toggle = (toggle_mask != 3'b000);
    op_o.leds   = leds_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= 2'b00;
      leds_q      <= 3'b000;
      init_leds_q <= 3'b000;
      started_q   <= 1'b0;
    end else begin
      if (cfg_load) begin
        init_leds_q <= cfg_initial_leds_i;
        leds_q      <= cfg_initial_leds_i;
      end
      if (accept) begin
        started_q <= 1'b1;
        shift_q   <= shift_d;
        leds_q    <= leds_d;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/kst_fifo.sv -----
// two-entry queue of classified bytes between front and back
`default_nettype none
module kst_fifo
  import kst_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire kst_op_t data_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    pop_i,
  output kst_op_t      data_o
);

  kst_op_t    entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/kst_back.sv -----
// back end: emits results in order and runs the keyboard command queue
`default_nettype none
module kst_back
  import kst_pkg::*;
#(
  parameter int CMD_QUEUE_DEPTH = KST_CMD_QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       op_valid_i,
  input  wire kst_op_t    op_i,
  output logic            op_pop_o,
  input  wire logic [2:0] boot_leds_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      value_o,
  output logic            last_o
);

  localparam int AW = $clog2(CMD_QUEUE_DEPTH);
  localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);

  kst_state_e state_q, state_d;
  kst_op_t    op_q;
  logic       started_q;
  logic       awaiting_q;
  logic [7:0] pending_q;
  logic [1:0] boot_rem_q;
  logic [CW-1:0] ram_cnt_q;
  logic [AW-1:0] ram_wr_q;
  logic [AW-1:0] ram_rd_q;
  logic [7:0] ram_rdata;
  logic [CW-1:0] total_cnt;
  logic       q_full;
  logic       send_ok;
  logic       can_emit;
  logic       mid_any;
  logic       resend_emit;
  logic       mid_emit;
  logic       await_after;
  logic       final_send;
  logic [7:0] head_byte;

  logic       emit;
  logic [2:0] emit_kind;
  logic [7:0] emit_value;
  logic       emit_last;
  logic       do_send;
  logic       set_started;
  logic       clr_await;
  logic       ram_we;
  logic [7:0] ram_wdata;

  logic       out_valid_q;
  logic [2:0] kind_q;
  logic [7:0] value_q;
  logic       last_q;

  assign total_cnt   = CW'(boot_rem_q) + ram_cnt_q;
  assign q_full      = (total_cnt >= CW'(CMD_QUEUE_DEPTH));
  assign send_ok     = !awaiting_q && (total_cnt != '0);
  assign can_emit    = !out_valid_q || out_ready_i;
  assign mid_any     = (op_q.ch != 8'h00) || op_q.bksp || op_q.tab || op_q.enter;
  assign resend_emit = op_q.resend && awaiting_q;
  assign mid_emit    = mid_any || resend_emit;
  assign await_after = awaiting_q && !op_q.ack;
  // lock puts leave the queue non-empty, so a send follows when nothing awaits
  assign final_send  = !await_after && ((total_cnt != '0) || op_q.toggle);

  // the two start-up bytes live outside the ram
  always_comb begin
    case (boot_rem_q)
      2'd2:    head_byte = KST_CODE_LED_CMD;
      2'd1:    head_byte = {5'b00000, boot_leds_i};
      default: head_byte = ram_rdata;
    endcase
  end

  kst_ram #(
    .WIDTH (8),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_wr_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_rd_q),
    .rdata_o (ram_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          state_d = started_q ? ST_MID : ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (can_emit) begin
          state_d = ST_MID;
        end
      end
      ST_MID: begin
        if (!mid_emit || can_emit) begin
          state_d = op_q.toggle ? ST_PUT_CMD : ST_SEND;
        end
      end
      ST_PUT_CMD: state_d = ST_PUT_LED;
      ST_PUT_LED: state_d = ST_SETTLE;
      // lets the registered ram read see the new entries before the send
      ST_SETTLE:  state_d = ST_SEND;
      ST_SEND: begin
        if (!send_ok || can_emit) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // actions per state
  always_comb begin
    op_pop_o    = 1'b0;
    emit        = 1'b0;
    emit_kind   = KST_KIND_CHAR;
    emit_value  = 8'h00;
    emit_last   = 1'b0;
    do_send     = 1'b0;
    set_started = 1'b0;
    clr_await   = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = KST_CODE_LED_CMD;
    unique case (state_q)
      ST_IDLE: begin
        op_pop_o = op_valid_i;
      end
      ST_FIRST: begin
        if (can_emit) begin
          emit        = 1'b1;
          emit_kind   = KST_KIND_SEND;
          emit_value  = head_byte;
          emit_last   = !(mid_any || op_q.resend || op_q.ack);
          do_send     = 1'b1;
          set_started = 1'b1;
        end
      end
      ST_MID: begin
        if (!mid_emit || can_emit) begin
          emit      = mid_emit;
          emit_last = !final_send;
          clr_await = op_q.ack;
          if (op_q.ch != 8'h00) begin
            emit_kind  = KST_KIND_CHAR;
            emit_value = op_q.ch;
          end else if (op_q.bksp) begin
            emit_kind = KST_KIND_BACKSPACE;
          end else if (op_q.tab) begin
            emit_kind = KST_KIND_TAB;
          end else if (op_q.enter) begin
            emit_kind = KST_KIND_ENTER;
          end else begin
            emit_kind  = KST_KIND_SEND;
            emit_value = pending_q;
          end
        end
      end
      ST_PUT_CMD: begin
        ram_we    = !q_full;
        ram_wdata = KST_CODE_LED_CMD;
      end
      ST_PUT_LED: begin
        ram_we    = !q_full;
        ram_wdata = {5'b00000, op_q.leds};
      end
      ST_SETTLE: begin
        ram_we = 1'b0;
      end
      ST_SEND: begin
        if (send_ok && can_emit) begin
          emit       = 1'b1;
          emit_kind  = KST_KIND_SEND;
          emit_value = head_byte;
          emit_last  = 1'b1;
          do_send    = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      awaiting_q  <= 1'b0;
      boot_rem_q  <= 2'd2;
      ram_cnt_q   <= '0;
      ram_wr_q    <= '0;
      ram_rd_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (set_started) begin
        started_q <= 1'b1;
      end
      if (do_send) begin
        awaiting_q <= 1'b1;
      end else if (clr_await) begin
        awaiting_q <= 1'b0;
      end
      if (do_send) begin
        if (boot_rem_q != 2'd0) begin
          boot_rem_q <= boot_rem_q - 2'd1;
        end else begin
          ram_rd_q  <= (ram_rd_q == AW'(CMD_QUEUE_DEPTH - 1)) ? '0 : ram_rd_q + 1'b1;
          ram_cnt_q <= ram_cnt_q - 1'b1;
        end
      end
      if (ram_we) begin
        ram_wr_q  <= (ram_wr_q == AW'(CMD_QUEUE_DEPTH - 1)) ? '0 : ram_wr_q + 1'b1;
        ram_cnt_q <= ram_cnt_q + 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      op_q <= op_i;
    end
    if (do_send) begin
      pending_q <= head_byte;
    end
    if (emit) begin
      kind_q  <= emit_kind;
      value_q <= emit_value;
      last_q  <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

  a_queue_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_cnt <= CW'(CMD_QUEUE_DEPTH))
    else $error("command queue count above depth");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> can_emit)
    else $error("result written over an untaken result");

  a_send_sets_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_send |=> awaiting_q)
    else $error("byte sent without waiting for acknowledge");

  a_first_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIRST) |-> (!started_q && boot_rem_q == 2'd2))
    else $error("start-up send outside the first item");

  a_boot_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    boot_rem_q != 2'd3)
    else $error("start-up byte count out of range");

endmodule
`default_nettype wire

// ----- sv/keyboard_scancode_translator_unit.sv -----
// top level: scan code set 1 to character translator with keyboard led command queue
// the back end sequencer finishes each byte before it takes the next; the first byte adds the
//   start-up send, and a lock key adds two command queue writes plus a ram settle through the
//   single ram write port
// reset: asynchronous, active low; queue comes up holding the led command and initial led byte,
//   with no clearing pass
`default_nettype none
module keyboard_scancode_translator_unit
  import kst_pkg::*;
#(
  parameter int CMD_QUEUE_DEPTH = KST_CMD_QUEUE_DEPTH
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] code_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [2:0]      kind_o,
  output logic [7:0]      value_o,
  output logic            last_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [2:0] cfg_initial_leds_i
);

  logic    fifo_full;
  logic    fifo_push;
  kst_op_t fifo_wdata;
  logic    fifo_valid;
  logic    fifo_pop;
  kst_op_t fifo_rdata;
  logic [2:0] boot_leds;

  kst_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .code_i             (code_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_initial_leds_i (cfg_initial_leds_i),
    .fifo_full_i        (fifo_full),
    .push_o             (fifo_push),
    .op_o               (fifo_wdata),
    .boot_leds_o        (boot_leds)
  );

  kst_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (fifo_pop),
    .data_o  (fifo_rdata)
  );

  kst_back #(
    .CMD_QUEUE_DEPTH (CMD_QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (fifo_valid),
    .op_i        (fifo_rdata),
    .op_pop_o    (fifo_pop),
    .boot_leds_i (boot_leds),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .value_o     (value_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// ----- tb/kst_event_checker.sv -----
// checker: watches the translator's channels, predicts each result and compares
`timescale 1ns / 100ps
module kst_event_checker
  import kst_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic [7:0] code_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [2:0] kind_i,
  input  wire logic [7:0] value_i,
  input  wire logic       last_i,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_ready_i,
  input  wire logic [2:0] cfg_initial_leds_i,
  output int              mismatch_count_o,
  output int              outstanding_o
);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       last;
  } key_event_t;

  key_event_t expected_events[$];
  key_event_t step_events[$];

  // translator state as seen from outside
  logic [1:0] shift_held;
  logic [2:0] led_bits;
  logic       awaiting_ack;
  logic [7:0] sent_byte;
  logic       started;
  logic [7:0] led_cmd_fifo[$];

  function automatic logic [7:0] char_for(input logic [6:0] c, input logic shifted);
    string row;
    int    idx;
    logic [7:0] ch;
    ch  = 8'h00;
    row = "";
    idx = 0;
    if (c >= 7'h01 && c <= 7'h0D) begin
      row = shifted ? "~!@#$%^&*()_+" : "`1234567890-=";
      idx = int'(c) - 'h01;
    end else if (c >= 7'h10 && c <= 7'h19) begin
      row = "QWERTYUIOP";
      idx = int'(c) - 'h10;
    end else if (c >= 7'h1A && c <= 7'h1B) begin
      row = shifted ? "{}" : "[]";
      idx = int'(c) - 'h1A;
    end else if (c >= 7'h1E && c <= 7'h26) begin
      row = "ASDFGHJKL";
      idx = int'(c) - 'h1E;
    end else if (c >= 7'h27 && c <= 7'h28) begin
      row = shifted ? ":\"" : ";'";
      idx = int'(c) - 'h27;
    end else if (c >= 7'h2C && c <= 7'h32) begin
      row = "ZXCVBNM";
      idx = int'(c) - 'h2C;
    end else if (c >= 7'h33 && c <= 7'h35) begin
      row = shifted ? "<>?" : ",./";
      idx = int'(c) - 'h33;
    end else if (c >= 7'h47 && c <= 7'h53) begin
      row = "789-456+1230.";
      idx = int'(c) - 'h47;
    end
    if (row.len() != 0) begin
      ch = row.getc(idx);
    end else if (c == 7'h2B || c == 7'h7D) begin
      ch = shifted ? 8'h7C : 8'h5C;
    end else if (c == 7'h73) begin
      ch = shifted ? 8'h5F : 8'h5C;
    end else if (c == 7'h37) begin
      ch = 8'h2A;
    end else if (c == 7'h39) begin
      ch = 8'h20;
    end
    return ch;
  endfunction

  task automatic add_event(input logic [2:0] kind, input logic [7:0] value);
    key_event_t ev;
    if (step_events.size() < 3) begin
      ev.kind  = kind;
      ev.value = value;
      ev.last  = 1'b0;
      step_events.push_back(ev);
    end
  endtask

  task automatic send_next();
    if (led_cmd_fifo.size() != 0 && !awaiting_ack) begin
      sent_byte    = led_cmd_fifo.pop_front();
      awaiting_ack = 1'b1;
      add_event(KST_KIND_SEND, sent_byte);
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    // a full queue drops the byte
    if (led_cmd_fifo.size() < KST_CMD_QUEUE_DEPTH) led_cmd_fifo.push_back(b);
  endtask

  task automatic toggle_lock(input logic [2:0] mask);
    led_bits = led_bits ^ mask;
    queue_byte(KST_CODE_LED_CMD);
    queue_byte({5'd0, led_bits});
  endtask

  task automatic load_start_leds(input logic [2:0] v);
    if (!started) begin
      led_bits     = v;
      led_cmd_fifo = '{KST_CODE_LED_CMD, {5'd0, v}};
    end
  endtask

  task automatic translate_code(input logic [7:0] c);
    logic [7:0] ch;
    logic       shifted;
    key_event_t ev;
    step_events.delete();
    if (!started) begin
      started = 1'b1;
      send_next();
    end
    shifted = (shift_held != 2'b00);
    ch = c[7] ? 8'h00 : char_for(c[6:0], shifted);
    // letters go lower case when caps lock and shift agree
    if (ch >= KST_UPPER_A && ch <= KST_UPPER_Z && (led_bits[2] == shifted))
      ch = ch + KST_CASE_OFFSET;
    if (ch != 8'h00) add_event(KST_KIND_CHAR, ch);
    case (c)
      KST_CODE_BACKSPACE:  add_event(KST_KIND_BACKSPACE, 8'h00);
      KST_CODE_TAB:        add_event(KST_KIND_TAB, 8'h00);
      KST_CODE_LSHIFT_ON:  shift_held[0] = 1'b1;
      KST_CODE_RSHIFT_ON:  shift_held[1] = 1'b1;
      KST_CODE_LSHIFT_OFF: shift_held[0] = 1'b0;
      KST_CODE_RSHIFT_OFF: shift_held[1] = 1'b0;
      KST_CODE_CAPS:       toggle_lock(KST_LED_CAPS);
      KST_CODE_NUM:        toggle_lock(KST_LED_NUM);
      KST_CODE_SCROLL:     toggle_lock(KST_LED_SCROLL);
      KST_CODE_ACK:        awaiting_ack = 1'b0;
      KST_CODE_RESEND: begin
        if (awaiting_ack) add_event(KST_KIND_SEND, sent_byte);
      end
      KST_CODE_ENTER:      add_event(KST_KIND_ENTER, 8'h00);
      default: ;
    endcase
    send_next();
    if (step_events.size() != 0) step_events[step_events.size() - 1].last = 1'b1;
    foreach (step_events[i]) begin
      ev = step_events[i];
      expected_events.push_back(ev);
    end
  endtask

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, exp_v, got_v);
    mismatch_count_o = mismatch_count_o + 1;
  endtask

  task automatic check_event();
    key_event_t ev;
    if (expected_events.size() == 0) begin
      report_mismatch("unexpected transfer, kind", 0, kind_i);
    end else begin
      ev = expected_events.pop_front();
      if (ev.kind != kind_i) report_mismatch("kind", ev.kind, kind_i);
      if (ev.value != value_i) report_mismatch("value", ev.value, value_i);
      if (ev.last != last_i) report_mismatch("last", ev.last, last_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_events.delete();
      shift_held   = 2'b00;
      awaiting_ack = 1'b0;
      sent_byte    = 8'h00;
      started      = 1'b0;
      load_start_leds(3'd0);
    end else begin
      if (out_valid_i && out_ready_i) check_event();
      if (cfg_valid_i && cfg_ready_i) load_start_leds(cfg_initial_leds_i);
      if (in_valid_i && in_ready_i) translate_code(code_i);
    end
    outstanding_o = expected_events.size();
  end

endmodule

// ----- tb/tb_keyboard_scancode_translator_unit.sv -----
// testbench top: drives scan codes and led settings into the translator and gives the verdict
`timescale 1ns / 100ps
module tb_keyboard_scancode_translator_unit
  import kst_pkg::*;
();

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] code_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [2:0] kind_o;
  logic [7:0] value_o;
  logic       last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [2:0] cfg_initial_leds_i;

  int   mismatch_count;
  int   outstanding;
  logic steady;       // no gaps on either side
  logic rx_long_hold; // receiver holds off for a long stretch

  keyboard_scancode_translator_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .code_i            (code_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .value_o           (value_o),
    .last_o            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_initial_leds_i(cfg_initial_leds_i)
  );

  kst_event_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .code_i            (code_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_i            (kind_o),
    .value_i           (value_o),
    .last_i            (last_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_initial_leds_i(cfg_initial_leds_i),
    .mismatch_count_o  (mismatch_count),
    .outstanding_o     (outstanding)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

  task automatic push_code(input logic [7:0] c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 7);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    code_i     <= c;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // lets the block drain, then waits on for an item still in flight
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_leds(input logic [2:0] v);
    @(negedge clk_i);
    cfg_initial_leds_i <= v;
    cfg_valid_i        <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] typed_code();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      c = 8'($urandom_range(0, 127));
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       c = KST_CODE_LSHIFT_ON;
        1:       c = KST_CODE_RSHIFT_ON;
        2:       c = KST_CODE_LSHIFT_OFF;
        default: c = KST_CODE_RSHIFT_OFF;
      endcase
    end else if (r < 53) begin
      case ($urandom_range(0, 2))
        0:       c = KST_CODE_CAPS;
        1:       c = KST_CODE_NUM;
        default: c = KST_CODE_SCROLL;
      endcase
    end else if (r < 68) begin
      c = KST_CODE_ACK;
    end else if (r < 73) begin
      c = KST_CODE_RESEND;
    end else if (r < 83) begin
      case ($urandom_range(0, 2))
        0:       c = KST_CODE_BACKSPACE;
        1:       c = KST_CODE_TAB;
        default: c = KST_CODE_ENTER;
      endcase
    end else begin
      c = 8'($urandom_range(0, 255));
    end
    return c;
  endfunction

  // receiver: random hold-off per result, or one long hold on request
  initial begin
    int hold;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_long_hold) begin
        hold = 80;
        rx_long_hold = 1'b0;
      end else begin
        hold = steady ? 0 : $urandom_range(0, 7);
      end
      if (hold > 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (hold - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    logic [7:0] opening[$];
    logic [7:0] lock_keys[3];
    in_valid_i         = 1'b0;
    code_i             = 8'h00;
    cfg_valid_i        = 1'b0;
    cfg_initial_leds_i = 3'd0;
    steady             = 1'b0;
    rx_long_hold       = 1'b0;
    rst_ni             = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // led settings before the first byte decide the start-up command
    write_leds(3'd0);
    write_leds(3'($urandom_range(1, 6)));
    write_leds(3'd7);

    opening = '{8'h1E, KST_CODE_ACK, KST_CODE_ACK, 8'h00, 8'h7F, 8'h80, 8'hFF,
                KST_CODE_BACKSPACE, KST_CODE_TAB, KST_CODE_ENTER,
                KST_CODE_LSHIFT_ON, 8'h1E, 8'h35, KST_CODE_ENTER, KST_CODE_RSHIFT_ON,
                KST_CODE_LSHIFT_OFF, 8'h73, KST_CODE_RSHIFT_OFF, KST_CODE_RESEND,
                KST_CODE_CAPS, KST_CODE_RESEND, KST_CODE_ACK, KST_CODE_NUM,
                KST_CODE_SCROLL, KST_CODE_ACK, KST_CODE_ACK, KST_CODE_ACK, KST_CODE_ACK};
    foreach (opening[i]) push_code(opening[i]);
    wait_idle();

    // after start these writes are ignored
    write_leds(3'd0);
    write_leds(3'($urandom_range(0, 7)));
    repeat (25) push_code(typed_code());

    // hold the receiver and flood lock keys so the block and its queue fill up
    wait_idle();
    write_leds(3'd7);
    lock_keys = '{KST_CODE_CAPS, KST_CODE_NUM, KST_CODE_SCROLL};
    steady       = 1'b1;
    rx_long_hold = 1'b1;
    repeat (18) push_code(lock_keys[$urandom_range(0, 2)]);
    steady = 1'b0;
    wait_idle();
    repeat (34) push_code(KST_CODE_ACK);
    wait_idle();

    write_leds(3'($urandom_range(0, 7)));
    steady = 1'b1;
    repeat (15) push_code(typed_code());
    steady = 1'b0;
    repeat (15) push_code(typed_code());
    wait_idle();

    if (mismatch_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
